// ===== design/sllf_pkg.sv =====
package sllf_pkg;

    typedef enum logic [2:0] {
        PH_CONNECT = 3'd0,
        PH_ACCEPT  = 3'd1,
        PH_OPEN    = 3'd2,
        PH_CLOSED  = 3'd3,
        PH_FAILED  = 3'd4,
        PH_EMPTY   = 3'd5
    } t_phase;

    typedef enum logic [2:0] {
        MSG_NONE    = 3'd0,
        MSG_CONNECT = 3'd1,
        MSG_ACCEPT  = 3'd2,
        MSG_RENEW   = 3'd3,
        MSG_CLOSE   = 3'd4
    } t_msg;

    typedef enum logic [3:0] {
        ERR_NONE      = 4'd0,
        ERR_SOCKET    = 4'd1,
        ERR_SEND      = 4'd2,
        ERR_RECEIVE   = 4'd3,
        ERR_FIELD     = 4'd4,
        ERR_SEQUENCE  = 4'd5,
        ERR_TIMEOUT   = 4'd6,
        ERR_HANDLER   = 4'd7,
        ERR_DUPLICATE = 4'd8
    } t_err;

    typedef enum logic [2:0] {
        HDR_CONNECT     = 3'd0,
        HDR_ACCEPT      = 3'd1,
        HDR_CLOSE       = 3'd2,
        HDR_RENEW       = 3'd3,
        HDR_PUBLISH     = 3'd4,
        HDR_SUBSCRIBE   = 3'd5,
        HDR_UNSUBSCRIBE = 3'd6,
        HDR_OTHER       = 3'd7
    } t_hdr;

    typedef enum logic [1:0] {
        ACT_PASS   = 2'd0,
        ACT_ADD    = 2'd1,
        ACT_DELETE = 2'd2
    } t_action;

    typedef enum logic [1:0] {
        RX_NONE  = 2'd0,
        RX_VALID = 2'd1,
        RX_ERROR = 2'd2
    } t_rx_status;

    typedef enum logic [1:0] {
        CFG_RETRY_LIMIT    = 2'd0,
        CFG_BASE_LEASE_MS  = 2'd1,
        CFG_RETAIN_SESSION = 2'd2,
        CFG_BUFFER_MTU     = 2'd3
    } t_cfg_idx;

    localparam logic [3:0]  RETRY_LIMIT_RST = 4'd5;
    localparam logic [31:0] BASE_LEASE_RST  = 32'd500;
    localparam logic [15:0] BUFFER_MTU_RST  = 16'd1024;
    localparam logic [4:0]  RETRY_CAP       = 5'd16;
    localparam logic [15:0] MTU_INVALID     = 16'hFFFF;
    localparam logic [31:0] LEASE_INVALID   = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [3:0]  retry_limit;
        logic [31:0] base_lease_ms;
        logic        retain_session;
        logic [15:0] buffer_mtu;
    } t_cfg;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] now_ms;
        logic        socket_ok;
        logic        send_ok;
        logic [1:0]  rx_status;
        logic [2:0]  rx_header;
        logic [15:0] rx_mtu;
        logic [31:0] rx_lease_ms;
        logic        handler_ok;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  send_kind;
        logic [31:0] send_lease_ms;
        logic [2:0]  session_state;
        logic [3:0]  error_code;
        logic        opened;
        logic        drop_subscriptions;
        logic        release_session;
        logic        mtu_changed;
        logic [15:0] current_mtu;
    } t_out_item;

endpackage

// ===== design/sllf_cfg_regs.sv =====
module sllf_cfg_regs (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_wr_en,
    input  logic [1:0]          i_wr_index,
    input  logic [31:0]         i_wr_data,
    output sllf_pkg::t_cfg      o_cfg
);
    import sllf_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.retry_limit    <= RETRY_LIMIT_RST;
            r_cfg.base_lease_ms  <= BASE_LEASE_RST;
            r_cfg.retain_session <= 1'b0;
            r_cfg.buffer_mtu     <= BUFFER_MTU_RST;
        end else if (i_wr_en) begin
            case (t_cfg_idx'(i_wr_index))
                CFG_RETRY_LIMIT:    r_cfg.retry_limit    <= i_wr_data[3:0];
                CFG_BASE_LEASE_MS:  r_cfg.base_lease_ms  <= i_wr_data;
                CFG_RETAIN_SESSION: r_cfg.retain_session <= i_wr_data[0];
                CFG_BUFFER_MTU:     r_cfg.buffer_mtu     <= i_wr_data[15:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== design/sllf_core.sv =====
module sllf_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  sllf_pkg::t_cfg       i_cfg,
    input  logic                 i_fire,
    input  sllf_pkg::t_in_item   i_item,
    output sllf_pkg::t_out_item  o_result
);
    import sllf_pkg::*;

    t_phase      r_phase, n_phase;
    logic [4:0]  r_retry, n_retry;
    logic [31:0] r_lease, n_lease;
    logic [31:0] r_last_heard, n_last_heard;
    logic [31:0] r_last_renew, n_last_renew;
    logic        r_accept_done, n_accept_done;
    logic [15:0] r_mtu, n_mtu;

    t_err        w_err;
    t_msg        w_kind;
    logic [31:0] w_send_lease;
    logic        w_opened, w_drop, w_release, w_mtu_chg;

    // offer carried by a received connect or accept
    logic        w_offer_mtu_bad, w_offer_lease_bad, w_offer_mtu_chg, w_offer_send;
    logic [15:0] w_offer_mtu;
    logic [31:0] w_offer_lease;
    logic        w_offer_accept_done;
    t_err        w_offer_err;

    logic [36:0] w_accept_wait;
    logic [31:0] w_accept_elapsed;
    logic        w_accept_expired;
    logic [31:0] w_open_heard;
    logic [31:0] w_open_elapsed;
    logic [31:0] w_renew_elapsed;
    logic        w_open_refresh;

    always_comb begin
        w_offer_mtu_bad   = (i_item.rx_mtu == MTU_INVALID);
        w_offer_lease_bad = (i_item.rx_lease_ms == LEASE_INVALID);
        w_offer_mtu_chg   = !w_offer_mtu_bad && (i_item.rx_mtu < r_mtu);
        w_offer_mtu       = w_offer_mtu_chg ? i_item.rx_mtu : r_mtu;
        w_offer_lease     = (!w_offer_lease_bad && (i_item.rx_lease_ms < r_lease)) ?
                            i_item.rx_lease_ms : r_lease;
        w_offer_send      = !w_offer_mtu_bad && !w_offer_lease_bad && !r_accept_done;
        w_offer_accept_done = r_accept_done | (w_offer_send & i_item.send_ok);
        if (w_offer_mtu_bad || w_offer_lease_bad)
            w_offer_err = ERR_FIELD;
        else if (w_offer_send && !i_item.send_ok)
            w_offer_err = ERR_SEND;
        else
            w_offer_err = ERR_NONE;
    end

    // retry wait grows with the retry count, formed at full width
    assign w_accept_wait    = 37'(r_lease) * 37'(r_retry);
    assign w_accept_elapsed = i_item.now_ms - r_last_heard;
    assign w_accept_expired = {5'd0, w_accept_elapsed} > w_accept_wait;

    assign w_open_refresh  = (t_rx_status'(i_item.rx_status) == RX_VALID) &&
                             (t_hdr'(i_item.rx_header) inside
                              {HDR_RENEW, HDR_PUBLISH, HDR_SUBSCRIBE, HDR_UNSUBSCRIBE});
    assign w_open_heard    = w_open_refresh ? i_item.now_ms : r_last_heard;
    assign w_open_elapsed  = i_item.now_ms - w_open_heard;
    assign w_renew_elapsed = i_item.now_ms - r_last_renew;

    always_comb begin
        n_phase       = r_phase;
        n_retry       = r_retry;
        n_lease       = r_lease;
        n_last_heard  = r_last_heard;
        n_last_renew  = r_last_renew;
        n_accept_done = r_accept_done;
        n_mtu         = r_mtu;
        w_err         = ERR_NONE;
        w_kind        = MSG_NONE;
        w_send_lease  = 32'd0;
        w_opened      = 1'b0;
        w_drop        = 1'b0;
        w_release     = 1'b0;
        w_mtu_chg     = 1'b0;

        case (t_action'(i_item.action))
            ACT_ADD: begin
                if (r_phase != PH_EMPTY) begin
                    w_err = ERR_DUPLICATE;
                end else begin
                    n_phase       = PH_CONNECT;
                    n_retry       = 5'd0;
                    n_lease       = 32'd0;
                    n_last_heard  = 32'd0;
                    n_last_renew  = 32'd0;
                    n_accept_done = 1'b0;
                    n_mtu         = i_cfg.buffer_mtu;
                end
            end
            ACT_DELETE: begin
                if (r_phase != PH_EMPTY) begin
                    if (r_phase != PH_CLOSED && r_phase != PH_FAILED) begin
                        n_phase = PH_CLOSED;
                        w_kind  = MSG_CLOSE;
                        if (!i_item.send_ok)
                            w_err = ERR_SEND;
                        else if (!i_item.socket_ok)
                            w_err = ERR_SOCKET;
                    end
                    if (w_err == ERR_NONE) begin
                        n_phase   = PH_EMPTY;
                        w_release = 1'b1;
                    end
                end
            end
            ACT_PASS: begin
                case (r_phase)
                    PH_EMPTY: ;
                    PH_CONNECT: begin
                        if (!i_item.socket_ok) begin
                            w_err = ERR_SOCKET;
                        end else begin
                            n_lease      = i_cfg.base_lease_ms;
                            w_kind       = MSG_CONNECT;
                            w_send_lease = i_cfg.base_lease_ms;
                            if (!i_item.send_ok)
                                w_err = ERR_SEND;
                        end
                        if (w_err == ERR_NONE) begin
                            n_phase       = PH_ACCEPT;
                            n_retry       = 5'd1;
                            n_last_heard  = i_item.now_ms;
                            n_accept_done = 1'b0;
                        end else begin
                            n_phase = PH_FAILED;
                        end
                    end
                    PH_ACCEPT: begin
                        if (r_retry <= {1'b0, i_cfg.retry_limit}) begin
                            if (w_accept_expired) begin
                                if (r_retry < RETRY_CAP)
                                    n_retry = r_retry + 5'd1;
                                n_last_heard = i_item.now_ms;
                            end
                            case (t_rx_status'(i_item.rx_status))
                                RX_NONE: ;
                                RX_VALID: begin
                                    if (t_hdr'(i_item.rx_header) == HDR_CONNECT ||
                                        t_hdr'(i_item.rx_header) == HDR_ACCEPT) begin
                                        w_err         = w_offer_err;
                                        n_mtu         = w_offer_mtu;
                                        w_mtu_chg     = w_offer_mtu_chg;
                                        n_lease       = w_offer_lease;
                                        n_accept_done = w_offer_accept_done;
                                        n_last_heard  = i_item.now_ms;
                                        if (w_offer_send) begin
                                            w_kind       = MSG_ACCEPT;
                                            w_send_lease = w_offer_lease;
                                        end
                                        if (t_hdr'(i_item.rx_header) == HDR_ACCEPT &&
                                            w_offer_accept_done) begin
                                            n_last_renew = i_item.now_ms;
                                            n_phase      = PH_OPEN;
                                        end
                                    end else begin
                                        w_err = ERR_SEQUENCE;
                                    end
                                end
                                default: w_err = ERR_RECEIVE;
                            endcase
                        end else begin
                            n_phase = PH_CLOSED;
                        end
                        if (w_err != ERR_NONE)
                            n_phase = PH_FAILED;
                        else if (n_phase == PH_OPEN)
                            w_opened = 1'b1;
                    end
                    PH_OPEN: begin
                        case (t_rx_status'(i_item.rx_status))
                            RX_NONE: ;
                            RX_VALID: begin
                                if (t_hdr'(i_item.rx_header) == HDR_CLOSE)
                                    n_phase = PH_CLOSED;
                                else if (w_open_refresh &&
                                         t_hdr'(i_item.rx_header) != HDR_RENEW &&
                                         !i_item.handler_ok)
                                    w_err = ERR_HANDLER;
                            end
                            default: w_err = ERR_RECEIVE;
                        endcase
                        n_last_heard = w_open_heard;
                        // a timeout wins over everything, a renew outcome over rx errors
                        if (w_open_elapsed > r_lease) begin
                            w_err = ERR_TIMEOUT;
                        end else if (w_renew_elapsed > {1'b0, r_lease[31:1]}) begin
                            w_kind       = MSG_RENEW;
                            w_err        = i_item.send_ok ? ERR_NONE : ERR_SEND;
                            n_last_renew = i_item.now_ms;
                        end
                        if (w_err != ERR_NONE)
                            n_phase = PH_FAILED;
                    end
                    PH_CLOSED: begin
                        if (!i_item.socket_ok) begin
                            w_err = ERR_SOCKET;
                        end else if (i_cfg.retain_session) begin
                            w_drop  = 1'b1;
                            n_phase = PH_CONNECT;
                        end else begin
                            w_release = 1'b1;
                            n_phase   = PH_EMPTY;
                        end
                    end
                    PH_FAILED: n_phase = PH_CLOSED;
                    default:   n_phase = PH_FAILED;
                endcase
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_EMPTY;
            r_retry       <= 5'd0;
            r_lease       <= 32'd0;
            r_last_heard  <= 32'd0;
            r_last_renew  <= 32'd0;
            r_accept_done <= 1'b0;
            r_mtu         <= BUFFER_MTU_RST;
        end else if (i_fire) begin
            r_phase       <= n_phase;
            r_retry       <= n_retry;
            r_lease       <= n_lease;
            r_last_heard  <= n_last_heard;
            r_last_renew  <= n_last_renew;
            r_accept_done <= n_accept_done;
            r_mtu         <= n_mtu;
        end
    end

    always_comb begin
        o_result.send_kind          = w_kind;
        o_result.send_lease_ms      = w_send_lease;
        o_result.session_state      = n_phase;
        o_result.error_code         = w_err;
        o_result.opened             = w_opened;
        o_result.drop_subscriptions = w_drop;
        o_result.release_session    = w_release;
        o_result.mtu_changed        = w_mtu_chg;
        o_result.current_mtu        = n_mtu;
    end

    a_retry_capped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_retry <= RETRY_CAP)
        else $error("retry count past its cap");

    a_mtu_only_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && t_action'(i_item.action) != ACT_ADD) |=> (r_mtu <= $past(r_mtu)))
        else $error("mtu grew outside an add");

    a_accept_done_in_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_accept_done) |-> ($past(r_phase) == PH_ACCEPT))
        else $error("accept flag set outside the accept phase");

endmodule

// ===== design/session_lease_lifecycle_fsm.sv =====
// session lease lifecycle controller for a single peer session
//
// input channel: one beat of t_in_item per step (task pass, add, delete),
// accepted when i_in_valid is high and o_in_stall is low
// output channel: exactly one t_out_item per input beat, in order,
// taken when o_out_valid is high and i_out_stall is low
// config channel: i_cfg_valid/o_cfg_ready with a 2-bit register index and
// 32-bit data; o_cfg_ready is always high, write only while the block is idle
//
// an input beat is held in the input register, then goes through the step
// logic into the result register
// throughput is one item per cycle while the result is not stalled; the
// state update (phase, retries, lease, ticks, mtu) of one step completes in
// the same cycle that the item leaves the input register, so the next item
// sees it straight away; a stalled result holds in the result register, and
// the input register takes at most one more beat, then o_in_stall rises
// reset: both channels empty, session phase empty, config registers load
// retry limit 5, lease 500 ms, no retain, buffer mtu 1024
module session_lease_lifecycle_fsm (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  sllf_pkg::t_in_item   i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output sllf_pkg::t_out_item  o_out_item,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [1:0]           i_cfg_index,
    input  logic [31:0]          i_cfg_data
);
    import sllf_pkg::*;

    t_cfg      w_cfg;
    logic      r_in_valid;
    t_in_item  r_in_item;
    logic      r_out_valid;
    t_out_item r_out_item;
    t_out_item w_result;
    logic      w_fire;

    assign o_cfg_ready = 1'b1;

    sllf_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid && o_cfg_ready),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    // step the item in the input register when the result slot frees up
    assign w_fire     = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !w_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (!o_in_stall)
                r_in_valid <= i_in_valid;
            if (w_fire)
                r_out_valid <= 1'b1;
            else if (!i_out_stall)
                r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall)
            r_in_item <= i_in_item;
        if (w_fire)
            r_out_item <= w_result;
    end

    sllf_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (w_cfg),
        .i_fire   (w_fire),
        .i_item   (r_in_item),
        .o_result (w_result)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    a_release_is_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_item.release_session) |->
        (t_phase'(r_out_item.session_state) == PH_EMPTY))
        else $error("release reported without an empty session");

    a_opened_is_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_item.opened) |->
        (t_phase'(r_out_item.session_state) == PH_OPEN &&
         t_err'(r_out_item.error_code) == ERR_NONE))
        else $error("opened reported without an open session");

    a_drop_is_reconnect: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_item.drop_subscriptions) |->
        (t_phase'(r_out_item.session_state) == PH_CONNECT))
        else $error("subscriptions dropped without a reconnect");

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import sllf_pkg::*;

    localparam logic [1:0]  ACT_UNKNOWN  = 2'd3;
    localparam logic [1:0]  RX_STRAY     = 2'd3;
    localparam logic [31:0] WRAP_BASE_MS = 32'hFFFF_FF00;
    localparam int          QUIET_LIMIT  = 2000;
    localparam int          HOLD_CYCLES  = 60;

    logic        i_clk;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic        o_in_stall;
    t_in_item    i_in_item   = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_out_item   o_out_item;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [31:0] i_cfg_data  = '0;

    session_lease_lifecycle_fsm dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // mirror of the session state and registers
    logic [3:0]  reg_retry_limit = RETRY_LIMIT_RST;
    logic [31:0] reg_base_lease  = BASE_LEASE_RST;
    logic        reg_retain      = 1'b0;
    logic [15:0] reg_buffer_mtu  = BUFFER_MTU_RST;
    t_phase      sess_phase      = PH_EMPTY;
    logic [4:0]  retries         = '0;
    logic [31:0] lease_agreed    = '0;
    logic [31:0] heard_ms        = '0;
    logic [31:0] renew_ms        = '0;
    logic        accept_given    = 1'b0;
    logic [15:0] mtu_now         = BUFFER_MTU_RST;

    t_out_item   pass_result;
    t_out_item   expected_passes[$];
    t_out_item   oldest;
    logic [31:0] clock_ms = 32'h0000_1000;
    int          errors = 0;
    int          quiet_cycles = 0;
    bit          idle_on = 1'b1;
    bit          hold_req = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic bit chance(input int unsigned pct);
        return $urandom_range(99) < pct;
    endfunction

    // mtu and lease of a peer connect or accept, may answer with an accept
    function automatic t_err absorb_peer_offer(input logic [15:0] offer_mtu,
                                               input logic [31:0] offer_lease,
                                               input logic send_ok);
        t_err err;
        err = ERR_NONE;
        if (offer_mtu == MTU_INVALID) begin
            err = ERR_FIELD;
        end else if (offer_mtu < mtu_now) begin
            mtu_now = offer_mtu;
            pass_result.mtu_changed = 1'b1;
        end
        if (offer_lease == LEASE_INVALID) begin
            err = ERR_FIELD;
        end else if (offer_lease < lease_agreed) begin
            lease_agreed = offer_lease;
        end
        if (err == ERR_NONE && !accept_given) begin
            pass_result.send_kind = MSG_ACCEPT;
            pass_result.send_lease_ms = lease_agreed;
            if (send_ok) accept_given = 1'b1;
            else err = ERR_SEND;
        end
        return err;
    endfunction

    function automatic t_out_item advance_session(input t_in_item it);
        t_err        err;
        logic [63:0] window;
        logic [63:0] elapsed;
        err = ERR_NONE;
        pass_result = '0;
        case (it.action)
            ACT_ADD: begin
                if (sess_phase != PH_EMPTY) begin
                    err = ERR_DUPLICATE;
                end else begin
                    sess_phase = PH_CONNECT;
                    retries = '0;
                    lease_agreed = '0;
                    heard_ms = '0;
                    renew_ms = '0;
                    accept_given = 1'b0;
                    mtu_now = reg_buffer_mtu;
                end
            end
            ACT_DELETE: begin
                if (sess_phase != PH_EMPTY) begin
                    if (sess_phase != PH_CLOSED && sess_phase != PH_FAILED) begin
                        sess_phase = PH_CLOSED;
                        pass_result.send_kind = MSG_CLOSE;
                        if (!it.send_ok) err = ERR_SEND;
                        else if (!it.socket_ok) err = ERR_SOCKET;
                    end
                    if (err == ERR_NONE) begin
                        sess_phase = PH_EMPTY;
                        pass_result.release_session = 1'b1;
                    end
                end
            end
            ACT_PASS: begin
                case (sess_phase)
                    PH_EMPTY: ;
                    PH_CONNECT: begin
                        if (!it.socket_ok) begin
                            err = ERR_SOCKET;
                        end else begin
                            lease_agreed = reg_base_lease;
                            pass_result.send_kind = MSG_CONNECT;
                            pass_result.send_lease_ms = lease_agreed;
                            if (!it.send_ok) err = ERR_SEND;
                        end
                        if (err == ERR_NONE) begin
                            sess_phase = PH_ACCEPT;
                            retries = 5'd1;
                            heard_ms = it.now_ms;
                            accept_given = 1'b0;
                        end else begin
                            sess_phase = PH_FAILED;
                        end
                    end
                    PH_ACCEPT: begin
                        if (retries <= {1'b0, reg_retry_limit}) begin
                            // retry window grows with the count, formed at full width
                            window = {32'd0, lease_agreed} * {59'd0, retries};
                            elapsed = {32'd0, it.now_ms - heard_ms};
                            if (elapsed > window) begin
                                if (retries < RETRY_CAP) retries = retries + 5'd1;
                                heard_ms = it.now_ms;
                            end
                            if (it.rx_status >= RX_ERROR) begin
                                err = ERR_RECEIVE;
                            end else if (it.rx_status == RX_VALID) begin
                                if (it.rx_header == HDR_CONNECT) begin
                                    err = absorb_peer_offer(it.rx_mtu, it.rx_lease_ms,
                                                            it.send_ok);
                                    heard_ms = it.now_ms;
                                end else if (it.rx_header == HDR_ACCEPT) begin
                                    err = absorb_peer_offer(it.rx_mtu, it.rx_lease_ms,
                                                            it.send_ok);
                                    heard_ms = it.now_ms;
                                    if (accept_given) begin
                                        renew_ms = it.now_ms;
                                        sess_phase = PH_OPEN;
                                    end
                                end else begin
                                    err = ERR_SEQUENCE;
                                end
                            end
                        end else begin
                            sess_phase = PH_CLOSED;
                        end
                        if (err != ERR_NONE) sess_phase = PH_FAILED;
                        else if (sess_phase == PH_OPEN) pass_result.opened = 1'b1;
                    end
                    PH_OPEN: begin
                        if (it.rx_status >= RX_ERROR) begin
                            err = ERR_RECEIVE;
                        end else if (it.rx_status == RX_VALID) begin
                            if (it.rx_header == HDR_CLOSE) begin
                                sess_phase = PH_CLOSED;
                            end else if (it.rx_header == HDR_RENEW) begin
                                heard_ms = it.now_ms;
                            end else if (it.rx_header == HDR_PUBLISH ||
                                         it.rx_header == HDR_SUBSCRIBE ||
                                         it.rx_header == HDR_UNSUBSCRIBE) begin
                                heard_ms = it.now_ms;
                                if (!it.handler_ok) err = ERR_HANDLER;
                            end
                        end
                        // timeout wins, else a due renew overrides earlier errors
                        if (it.now_ms - heard_ms > lease_agreed) begin
                            err = ERR_TIMEOUT;
                        end else if (it.now_ms - renew_ms > (lease_agreed >> 1)) begin
                            pass_result.send_kind = MSG_RENEW;
                            err = it.send_ok ? ERR_NONE : ERR_SEND;
                            renew_ms = it.now_ms;
                        end
                        if (err != ERR_NONE) sess_phase = PH_FAILED;
                    end
                    PH_CLOSED: begin
                        if (!it.socket_ok) begin
                            err = ERR_SOCKET;
                        end else if (reg_retain) begin
                            pass_result.drop_subscriptions = 1'b1;
                            sess_phase = PH_CONNECT;
                        end else begin
                            pass_result.release_session = 1'b1;
                            sess_phase = PH_EMPTY;
                        end
                    end
                    PH_FAILED: sess_phase = PH_CLOSED;
                    default: sess_phase = PH_FAILED;
                endcase
            end
            default: ;
        endcase
        pass_result.session_state = sess_phase;
        pass_result.error_code = err;
        pass_result.current_mtu = mtu_now;
        return pass_result;
    endfunction

    // mostly the beat the current phase is waiting for, with random content
    function automatic t_in_item shaped_item();
        t_in_item    it;
        logic [31:0] delta;
        if (chance(12)) begin
            it.action = 2'($urandom);
            it.now_ms = $urandom;
            it.socket_ok = 1'($urandom);
            it.send_ok = 1'($urandom);
            it.rx_status = 2'($urandom);
            it.rx_header = 3'($urandom);
            it.rx_mtu = 16'($urandom);
            it.rx_lease_ms = $urandom;
            it.handler_ok = 1'($urandom);
            return it;
        end
        it.action = ACT_PASS;
        it.socket_ok = chance(88);
        it.send_ok = chance(88);
        it.handler_ok = chance(85);
        it.rx_status = RX_NONE;
        it.rx_header = 3'($urandom);
        it.rx_mtu = chance(8) ? MTU_INVALID : 16'($urandom_range(MTU_INVALID - 1));
        it.rx_lease_ms = chance(50) ? $urandom_range(lease_agreed) : $urandom;
        if (chance(8)) it.rx_lease_ms = LEASE_INVALID;
        delta = $urandom_range(20);
        case (sess_phase)
            PH_EMPTY: begin
                if (chance(85)) it.action = ACT_ADD;
                else it.action = chance(50) ? ACT_DELETE : ACT_PASS;
            end
            PH_CONNECT: begin
                if (chance(6)) it.action = chance(50) ? ACT_ADD : ACT_DELETE;
            end
            PH_ACCEPT: begin
                if (chance(4)) it.action = ACT_DELETE;
                if (chance(30)) delta = lease_agreed * retries + $urandom_range(20, 1);
                if (chance(75)) it.rx_status = RX_VALID;
                else if (chance(20)) it.rx_status = RX_ERROR;
                if (chance(75)) it.rx_header = HDR_ACCEPT;
                else if (chance(50)) it.rx_header = HDR_CONNECT;
            end
            PH_OPEN: begin
                if (chance(4)) it.action = ACT_DELETE;
                if (chance(10)) delta = lease_agreed + $urandom_range(20, 1);
                else delta = $urandom_range(lease_agreed / 3 + 1);
                if (chance(55)) it.rx_status = RX_VALID;
                else if (chance(15)) it.rx_status = RX_ERROR;
                if (chance(50)) it.rx_header = HDR_RENEW;
                else if (chance(60))
                    it.rx_header = 3'($urandom_range(HDR_UNSUBSCRIBE, HDR_PUBLISH));
                else if (chance(20)) it.rx_header = HDR_CLOSE;
            end
            default: begin
                if (chance(10)) it.action = ACT_DELETE;
            end
        endcase
        clock_ms = clock_ms + delta;
        it.now_ms = clock_ms;
        return it;
    endfunction

    function automatic t_in_item mk(input logic [1:0] action, input logic [31:0] now_ms,
                                    input logic socket_ok, input logic send_ok,
                                    input logic [1:0] rx_status, input logic [2:0] rx_header,
                                    input logic [15:0] rx_mtu, input logic [31:0] rx_lease_ms,
                                    input logic handler_ok);
        t_in_item it;
        it.action = action;
        it.now_ms = now_ms;
        it.socket_ok = socket_ok;
        it.send_ok = send_ok;
        it.rx_status = rx_status;
        it.rx_header = rx_header;
        it.rx_mtu = rx_mtu;
        it.rx_lease_ms = rx_lease_ms;
        it.handler_ok = handler_ok;
        return it;
    endfunction

    task automatic send_beat(input t_in_item it);
        if (idle_on && chance(21)) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
            while (chance(21)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item <= it;
        do @(posedge i_clk); while (o_in_stall);
        expected_passes.push_back(advance_session(it));
    endtask

    task automatic drain_results();
        if (i_in_valid) i_in_valid <= 1'b0;
        while (expected_passes.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_RETRY_LIMIT:    reg_retry_limit = data[3:0];
            CFG_BASE_LEASE_MS:  reg_base_lease = data;
            CFG_RETAIN_SESSION: reg_retain = data[0];
            CFG_BUFFER_MTU:     reg_buffer_mtu = data[15:0];
            default: ;
        endcase
    endtask

    task automatic apply_settings(input logic [3:0] retry_limit, input logic [31:0] lease_ms,
                                  input logic retain, input logic [15:0] buffer_mtu);
        drain_results();
        write_reg(CFG_RETRY_LIMIT, {28'd0, retry_limit});
        write_reg(CFG_BASE_LEASE_MS, lease_ms);
        write_reg(CFG_RETAIN_SESSION, {31'd0, retain});
        write_reg(CFG_BUFFER_MTU, {16'd0, buffer_mtu});
        i_cfg_valid <= 1'b0;
    endtask

    task automatic test_special_cases();
        logic [31:0] w;
        w = WRAP_BASE_MS;
        // pass and delete with no session, then an unknown action
        send_beat(mk(ACT_PASS, w, 1'b1, 1'b1, RX_NONE, HDR_OTHER, 16'd0, 32'd0, 1'b1));
        send_beat(mk(ACT_DELETE, w, 1'b1, 1'b1, RX_NONE, HDR_OTHER, 16'd0, 32'd0, 1'b1));
        send_beat(mk(ACT_UNKNOWN, w, 1'b1, 1'b1, RX_NONE, HDR_OTHER, 16'd0, 32'd0, 1'b1));
        // add twice, socket start fails, failed -> closed, stop fails, then release
        send_beat(mk(ACT_ADD, w, 1'b1, 1'b1, RX_NONE, HDR_OTHER, 16'd0, 32'd0, 1'b1));
        send_beat(mk(ACT_ADD, w, 1'b1, 1'b1, RX_NONE, HDR_OTHER, 16'd0, 32'd0, 1'b1));
        send_beat(mk(ACT_PASS, w, 1'b0, 1'b1, RX_NONE, HDR_OTHER, 16'd0, 32'd0, 1'b1));
        send_beat(mk(ACT_PASS, w, 1'b1, 1'b1, RX_NONE, HDR_OTHER, 16'd0, 32'd0, 1'b1));
        send_beat(mk(ACT_PASS, w, 1'b0, 1'b1, RX_NONE, HDR_OTHER, 16'd0, 32'd0, 1'b1));
        send_beat(mk(ACT_PASS, w, 1'b1, 1'b1, RX_NONE, HDR_OTHER, 16'd0, 32'd0, 1'b1));
        // renew while waiting for accept is out of sequence
        send_beat(mk(ACT_ADD, w, 1'b1, 1'b1, RX_NONE, HDR_OTHER, 16'd0, 32'd0, 1'b1));
        send_beat(mk(ACT_PASS, w, 1'b1, 1'b1, RX_NONE, HDR_OTHER, 16'd0, 32'd0, 1'b1));
        send_beat(mk(ACT_PASS, w + 32'd50, 1'b1, 1'b1, RX_VALID, HDR_RENEW,
                     16'd0, 32'd0, 1'b1));
        send_beat(mk(ACT_DELETE, w, 1'b1, 1'b1, RX_NONE, HDR_OTHER, 16'd0, 32'd0, 1'b1));
        // invalid mtu, the smaller lease still taken
        send_beat(mk(ACT_ADD, w, 1'b1, 1'b1, RX_NONE, HDR_OTHER, 16'd0, 32'd0, 1'b1));
        send_beat(mk(ACT_PASS, w, 1'b1, 1'b1, RX_NONE, HDR_OTHER, 16'd0, 32'd0, 1'b1));
        send_beat(mk(ACT_PASS, w + 32'd10, 1'b1, 1'b1, RX_VALID, HDR_CONNECT,
                     MTU_INVALID, 32'd300, 1'b1));
        send_beat(mk(ACT_DELETE, w, 1'b1, 1'b1, RX_NONE, HDR_OTHER, 16'd0, 32'd0, 1'b1));
        // open with smaller mtu, renew masks a handler error, stray rx past tick wrap
        send_beat(mk(ACT_ADD, w, 1'b1, 1'b1, RX_NONE, HDR_OTHER, 16'd0, 32'd0, 1'b1));
        send_beat(mk(ACT_PASS, w, 1'b1, 1'b1, RX_NONE, HDR_OTHER, 16'd0, 32'd0, 1'b1));
        send_beat(mk(ACT_PASS, w + 32'd10, 1'b1, 1'b1, RX_VALID, HDR_ACCEPT,
                     16'd512, 32'd400, 1'b1));
        send_beat(mk(ACT_PASS, w + 32'd250, 1'b1, 1'b1, RX_VALID, HDR_PUBLISH,
                     16'd0, 32'd0, 1'b0));
        send_beat(mk(ACT_PASS, w + 32'd300, 1'b1, 1'b1, RX_STRAY, HDR_OTHER,
                     16'd0, 32'd0, 1'b1));
        send_beat(mk(ACT_DELETE, w, 1'b1, 1'b1, RX_NONE, HDR_OTHER, 16'd0, 32'd0, 1'b1));
    endtask

    task automatic test_session_traffic(input int count);
        repeat (count) send_beat(shaped_item());
    endtask

    // receiver holds off while the sender keeps offering, so the block fills up
    task automatic test_backpressure();
        drain_results();
        idle_on = 1'b0;
        hold_req = 1'b1;
        repeat (30) send_beat(shaped_item());
        idle_on = 1'b1;
        drain_results();
    endtask

    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else begin
                i_out_stall <= idle_on && chance(21);
            end
        end
    end

    task automatic check_field(input string label, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %0h actual %0h", $time, label, want, got);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_passes.size() == 0) begin
                $display("%0t: unexpected result beat, expected none actual %0h",
                         $time, o_out_item);
                errors++;
            end else begin
                oldest = expected_passes.pop_front();
                check_field("send_kind", 32'(oldest.send_kind),
                            32'(o_out_item.send_kind));
                check_field("send_lease_ms", oldest.send_lease_ms, o_out_item.send_lease_ms);
                check_field("session_state", 32'(oldest.session_state),
                            32'(o_out_item.session_state));
                check_field("error_code", 32'(oldest.error_code),
                            32'(o_out_item.error_code));
                check_field("opened", 32'(oldest.opened), 32'(o_out_item.opened));
                check_field("drop_subscriptions", 32'(oldest.drop_subscriptions),
                            32'(o_out_item.drop_subscriptions));
                check_field("release_session", 32'(oldest.release_session),
                            32'(o_out_item.release_session));
                check_field("mtu_changed", 32'(oldest.mtu_changed),
                            32'(o_out_item.mtu_changed));
                check_field("current_mtu", 32'(oldest.current_mtu),
                            32'(o_out_item.current_mtu));
            end
        end
    end

    // watchdog on cycles with no beat on any channel
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_special_cases();
        apply_settings(4'd1, 32'd1, 1'b1, 16'd1);
        test_session_traffic(70);
        apply_settings(4'd15, 32'hFFFF_FFFE, 1'b0, 16'hFFFE);
        test_session_traffic(70);
        apply_settings(4'd3, 32'd40, 1'b1, 16'd600);
        test_session_traffic(70);
        test_backpressure();
        idle_on = 1'b0;
        apply_settings(4'($urandom_range(15, 1)), $urandom_range(2000, 1), 1'($urandom),
                       16'($urandom_range(65534, 1)));
        test_session_traffic(80);
        idle_on = 1'b1;
        apply_settings(RETRY_LIMIT_RST, BASE_LEASE_RST, 1'b0, BUFFER_MTU_RST);
        test_session_traffic(70);
        drain_results();
        repeat (4) @(posedge i_clk);
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
